// ----- src/rpip_pkg.sv -----
`timescale 1ns / 1ps

package rpip_pkg;

  localparam int MaxVerticesDef = 64;
  localparam int CoordBitsDef   = 32;

  localparam int CountBits      = 7;
  localparam int SlotBits       = 6;
  localparam int PortCoordBits  = 32;

  // The winding sum is kept in quarter turns.
  localparam int WindFullDeg    = 360;
  localparam int WindStepDeg    = 90;
  localparam int WindFullSteps  = WindFullDeg / WindStepDeg;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDone
  } rpip_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic commit;
  } rpip_cmd_t;

  typedef struct packed {
    logic out_busy;
  } rpip_status_t;

endpackage

// ----- src/rpip_if.sv -----
`timescale 1ns / 1ps

interface rpip_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    kind;
  logic [rpip_pkg::SlotBits-1:0]           vertex_index;
  logic signed [rpip_pkg::PortCoordBits-1:0] x_coord;
  logic signed [rpip_pkg::PortCoordBits-1:0] y_coord;
  logic                                    last;

  modport source (output valid, kind, vertex_index, x_coord, y_coord, last, input ready);
  modport sink   (input valid, kind, vertex_index, x_coord, y_coord, last, output ready);
endinterface

interface rpip_out_if;
  logic valid;
  logic ready;
  logic point_inside;
  logic group_all_inside;
  logic group_end;

  modport source (output valid, point_inside, group_all_inside, group_end, input ready);
  modport sink   (input valid, point_inside, group_all_inside, group_end, output ready);
endinterface

// ----- src/rectilinear_point_in_polygon.sv -----
`timescale 1ns / 1ps

// Point-in-polygon tester for rectilinear outlines. Vertex loads write one entry
// of the vertex memory. A query walks the first n stored vertices (n is
// vertex_count, capped at MAX_VERTICES) through the single read port of that
// memory, one vertex per cycle, checking corners, edges and the quadrant winding
// sum in the same pass; its result is registered in the done state once the
// output is free, and only then does the block return to idle to take the next
// item. The result register lets the block take the next item while a result
// still waits; a query finishing while the previous result is still pending
// holds until that result is taken. The user must write vertex_count only while
// the block is idle, and the block does not enforce this; vertices that a query
// reads must have been loaded first.
module rectilinear_point_in_polygon #(
  parameter int MAX_VERTICES = rpip_pkg::MaxVerticesDef,
  parameter int COORD_BITS   = rpip_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rpip_pkg::CountBits-1:0] cfg_data_i,
  rpip_in_if.sink                        in_i,
  rpip_out_if.source                     out_o
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);

  rpip_pkg::rpip_cmd_t    cmd;
  rpip_pkg::rpip_status_t status;
  logic [CW-1:0]          n;
  logic [AW-1:0]          rd_addr;

  rpip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .n_i        (n),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  rpip_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd),
    .rd_addr_i          (rd_addr),
    .vertex_index_i     (in_i.vertex_index),
    .x_coord_i          (in_i.x_coord),
    .y_coord_i          (in_i.y_coord),
    .last_i             (in_i.last),
    .out_ready_i        (out_o.ready),
    .n_o                (n),
    .status_o           (status),
    .out_valid_o        (out_o.valid),
    .point_inside_o     (out_o.point_inside),
    .group_all_inside_o (out_o.group_all_inside),
    .group_end_o        (out_o.group_end)
  );

endmodule

// ----- src/rpip_ctrl.sv -----
`timescale 1ns / 1ps

module rpip_ctrl #(
  parameter int MAX_VERTICES = rpip_pkg::MaxVerticesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_kind_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]  n_i,
  input  rpip_pkg::rpip_status_t             status_i,
  output logic                               in_ready_o,
  output rpip_pkg::rpip_cmd_t                cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0]    rd_addr_o
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);

  rpip_pkg::rpip_state_e state_q, state_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  walk_end;

  assign walk_end  = (idx_q == n_i);
  assign rd_addr_o = idx_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      rpip_pkg::StIdle: begin
        if (in_valid_i && in_kind_i == rpip_pkg::KindQuery) state_d = rpip_pkg::StWalk;
      end
      rpip_pkg::StWalk: begin
        if (walk_end) state_d = rpip_pkg::StDone;
      end
      rpip_pkg::StDone: begin
        if (!status_i.out_busy) state_d = rpip_pkg::StIdle;
      end
      default: state_d = rpip_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    idx_d        = idx_q;
    case (state_q)
      rpip_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        idx_d        = '0;
        cmd_o.load   = in_valid_i && (in_kind_i == rpip_pkg::KindLoad);
        cmd_o.start  = in_valid_i && (in_kind_i == rpip_pkg::KindQuery);
      end
      rpip_pkg::StWalk: begin
        if (!walk_end) begin
          cmd_o.issue = 1'b1;
          idx_d       = idx_q + CW'(1);
        end
      end
      rpip_pkg::StDone: begin
        cmd_o.commit = !status_i.out_busy;
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpip_pkg::StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- src/rpip_datapath.sv -----
`timescale 1ns / 1ps

module rpip_datapath #(
  parameter int MAX_VERTICES = rpip_pkg::MaxVerticesDef,
  parameter int COORD_BITS   = rpip_pkg::CoordBitsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [rpip_pkg::CountBits-1:0]             cfg_data_i,
  input  rpip_pkg::rpip_cmd_t                        cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]            rd_addr_i,
  input  logic [rpip_pkg::SlotBits-1:0]              vertex_index_i,
  input  logic signed [rpip_pkg::PortCoordBits-1:0]  x_coord_i,
  input  logic signed [rpip_pkg::PortCoordBits-1:0]  y_coord_i,
  input  logic                                       last_i,
  input  logic                                       out_ready_i,
  output logic [$clog2(MAX_VERTICES+1)-1:0]          n_o,
  output rpip_pkg::rpip_status_t                     status_o,
  output logic                                       out_valid_o,
  output logic                                       point_inside_o,
  output logic                                       group_all_inside_o,
  output logic                                       group_end_o
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int WW = $clog2(MAX_VERTICES) + 2;

  // Vertex store: one write port for loads, one registered read port for the walk.
  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;

  logic [rpip_pkg::CountBits-1:0] count_q;
  logic [31:0]                    count_ext;

  logic signed [COORD_BITS-1:0] px_q, py_q, ax_q, ay_q;
  logic                         last_q, dv_q, has_prev_q;
  logic                         corner_q, edge_q;
  logic signed [WW-1:0]         wind_q, wind_d;
  logic                         corner_d, edge_d;
  logic                         group_q;
  logic                         out_valid_q, inside_q, all_q, end_q;

  logic agx, alx, agy, aly, bgx, blx, bgy, bly;
  logic qa1, qa2, qa3, qa4, qb1, qb2, qb3, qb4;
  logic step_up, step_dn, pt_inside;

  assign count_ext = 32'(count_q);
  assign n_o = (count_ext > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(count_ext);

  assign wr_en   = cmd_i.load && (32'(vertex_index_i) < 32'(MAX_VERTICES));
  assign wr_addr = AW'(vertex_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= x_coord_i[COORD_BITS-1:0];
      mem_y[wr_addr] <= y_coord_i[COORD_BITS-1:0];
    end
    rd_x_q <= mem_x[rd_addr_i];
    rd_y_q <= mem_y[rd_addr_i];
  end

  // Position of the previous vertex (a) and this vertex (b) against the point.
  assign agx = ax_q > px_q;
  assign alx = ax_q < px_q;
  assign agy = ay_q > py_q;
  assign aly = ay_q < py_q;
  assign bgx = rd_x_q > px_q;
  assign blx = rd_x_q < px_q;
  assign bgy = rd_y_q > py_q;
  assign bly = rd_y_q < py_q;

  assign qa1 = agx & agy;
  assign qa2 = alx & agy;
  assign qa3 = alx & aly;
  assign qa4 = agx & aly;
  assign qb1 = bgx & bgy;
  assign qb2 = blx & bgy;
  assign qb3 = blx & bly;
  assign qb4 = bgx & bly;

  assign step_up = (qa1 & qb2) | (qa2 & qb3) | (qa3 & qb4) | (qa4 & qb1);
  assign step_dn = (qa1 & qb4) | (qa2 & qb1) | (qa3 & qb2) | (qa4 & qb3);

  always_comb begin
    corner_d = corner_q;
    edge_d   = edge_q;
    wind_d   = wind_q;
    if (dv_q) begin
      if (rd_x_q == px_q && rd_y_q == py_q) corner_d = 1'b1;
      if (has_prev_q) begin
        if (ay_q == rd_y_q && py_q == ay_q) begin
          if ((alx & bgx) | (blx & agx)) edge_d = 1'b1;
        end else if (ax_q == rd_x_q && px_q == ax_q) begin
          if ((aly & bgy) | (bly & agy)) edge_d = 1'b1;
        end
        if (step_up) begin
          wind_d = wind_q + WW'(1);
        end else if (step_dn) begin
          wind_d = wind_q - WW'(1);
        end
      end
    end
  end

  assign pt_inside = corner_q | edge_q | (wind_q == WW'(rpip_pkg::WindFullSteps));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q   <= x_coord_i[COORD_BITS-1:0];
      py_q   <= y_coord_i[COORD_BITS-1:0];
      last_q <= last_i;
    end
    if (dv_q) begin
      ax_q <= rd_x_q;
      ay_q <= rd_y_q;
    end
    if (cmd_i.commit) begin
      inside_q <= pt_inside;
      all_q    <= group_q & pt_inside;
      end_q    <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dv_q        <= 1'b0;
      has_prev_q  <= 1'b0;
      corner_q    <= 1'b0;
      edge_q      <= 1'b0;
      wind_q      <= '0;
      group_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) count_q <= cfg_data_i;
      dv_q <= cmd_i.issue;
      if (cmd_i.start) begin
        has_prev_q <= 1'b0;
        corner_q   <= 1'b0;
        edge_q     <= 1'b0;
        wind_q     <= '0;
      end else begin
        if (dv_q) has_prev_q <= 1'b1;
        corner_q <= corner_d;
        edge_q   <= edge_d;
        wind_q   <= wind_d;
      end
      if (cmd_i.commit) begin
        group_q     <= last_q | (group_q & pt_inside);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy  = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign point_inside_o     = inside_q;
  assign group_all_inside_o = all_q;
  assign group_end_o        = end_q;

endmodule
